/* design/ysu_pkg.sv */
package ysu_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_ROW_DEFAULT    = 1024;
	localparam int VALUE_BITS_DEFAULT = 32;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;

	// Ratios are unsigned Q0.16, so a scaled product drops 16 bits.
	localparam int RATIO_BITS = 16;

	// Row counter width and the largest grid height.
	localparam int ROW_W     = 13;
	localparam int ROW_LIMIT = 8191;

	// Width of the raw grid size sums and of the position compares.
	localparam int GRID_SUM_W = 14;
	localparam int CMP_W      = 16;

	// Configuration port.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_INTERIOR_WIDTH  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_INTERIOR_HEIGHT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_GUARD_CELLS     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_RATIO_X         = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_RATIO_Y         = 3'd4;

	// Sweep kinds.
	localparam logic SWEEP_MAGNETIC = 1'b0;
	localparam logic SWEEP_ELECTRIC = 1'b1;

	// Configuration register set.
	typedef struct packed {
		logic [10:0] interior_width;
		logic [12:0] interior_height;
		logic [3:0]  guard_cells;
		logic [15:0] ratio_x;
		logic [15:0] ratio_y;
	} cfg_t;

	// Classification of one cell, made by the front.
	typedef struct packed {
		logic kind;
		logic in_region;
		logic last;
	} ctl_t;

endpackage

/* design/yee_field_stencil_update_core.sv */
// Yee leapfrog field update for a 2-D grid, one cell per transfer.
// An input transfer is written into the queue, then passes stages 1, 2 and 3 into the output
// register. Throughput: one cell per cycle unless m_tready low holds the output register, set
// by the single line-buffer port used once per cell; a four-entry queue splits cell
// classification from the arithmetic pipeline.
// Reset (arst_n low, asynchronous) restores default registers and counters, not the line buffer.
module yee_field_stencil_update_core #(
	parameter int MAX_ROW    = ysu_pkg::MAX_ROW_DEFAULT,
	parameter int VALUE_BITS = ysu_pkg::VALUE_BITS_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Configuration write channel.
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ysu_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [ysu_pkg::CFG_DATA_W-1:0]        cfg_data,
	// Cell input.
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((6*VALUE_BITS+7)/8)*8-1:0]     s_tdata,  // e_x, e_y, e_z, b_x, b_y, b_z
	input  logic [1:0]                            s_tuser,  // command, sweep_start
	// Result output.
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((3*VALUE_BITS+7)/8)*8-1:0]     m_tdata,  // out_x, out_y, out_z
	output logic [1:0]                            m_tuser,  // was_updated, saturated
	output logic                                  m_tlast   // sweep_end
);
	import ysu_pkg::*;

	localparam int COL_W  = $clog2(MAX_ROW);
	localparam int DATA_W = 6 * VALUE_BITS;
	localparam int CTL_W  = $bits(ctl_t);
	localparam int ITEM_W = CTL_W + COL_W + DATA_W;

	cfg_t              cfg;
	logic              push, q_in_ready, q_out_valid, q_out_ready;
	ctl_t              push_ctl, pop_ctl;
	logic [COL_W-1:0]  push_col, pop_col;
	logic [DATA_W-1:0] push_data, pop_data;
	logic [ITEM_W-1:0] q_in, q_out;

	// Configuration registers.
	ysu_config u_config (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Front: position tracking and classification.
	ysu_front #(
		.MAX_ROW    (MAX_ROW),
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (q_in_ready),
		.in_user   (s_tuser),
		.in_data   (s_tdata[DATA_W-1:0]),
		.push      (push),
		.push_ctl  (push_ctl),
		.push_col  (push_col),
		.push_data (push_data)
	);

	assign s_tready = q_in_ready;
	assign q_in     = {push_ctl, push_col, push_data};

	// Queue between front and back.
	ysu_queue #(
		.WIDTH (ITEM_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push),
		.in_ready  (q_in_ready),
		.in_data   (q_in),
		.out_valid (q_out_valid),
		.out_ready (q_out_ready),
		.out_data  (q_out)
	);

	assign pop_ctl  = ctl_t'(q_out[ITEM_W-1 -: CTL_W]);
	assign pop_col  = q_out[DATA_W +: COL_W];
	assign pop_data = q_out[DATA_W-1:0];

	// Back: line buffer, stencil arithmetic and output register.
	ysu_back #(
		.MAX_ROW    (MAX_ROW),
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (q_out_valid),
		.in_ready (q_out_ready),
		.in_ctl   (pop_ctl),
		.in_col   (pop_col),
		.in_data  (pop_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

/* design/ysu_config.sv */
module ysu_config (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ysu_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [ysu_pkg::CFG_DATA_W-1:0]      cfg_data,
	output ysu_pkg::cfg_t                       cfg
);
	import ysu_pkg::*;

	cfg_t cfg_q;

	// Writes are always taken.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register file; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interior_width  <= 11'd64;
			cfg_q.interior_height <= 13'd64;
			cfg_q.guard_cells     <= 4'd1;
			cfg_q.ratio_x         <= 16'd32768;
			cfg_q.ratio_y         <= 16'd32768;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_INTERIOR_WIDTH:  cfg_q.interior_width  <= cfg_data[10:0];
				CFG_INTERIOR_HEIGHT: cfg_q.interior_height <= cfg_data[12:0];
				CFG_GUARD_CELLS:     cfg_q.guard_cells     <= cfg_data[3:0];
				CFG_RATIO_X:         cfg_q.ratio_x         <= cfg_data[15:0];
				CFG_RATIO_Y:         cfg_q.ratio_y         <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

endmodule

/* design/ysu_front.sv */
module ysu_front #(
	parameter int MAX_ROW    = ysu_pkg::MAX_ROW_DEFAULT,
	parameter int VALUE_BITS = ysu_pkg::VALUE_BITS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ysu_pkg::cfg_t                 cfg,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [1:0]                    in_user,  // command, sweep_start
	input  logic [6*VALUE_BITS-1:0]       in_data,  // e_x, e_y, e_z, b_x, b_y, b_z
	output logic                          push,
	output ysu_pkg::ctl_t                 push_ctl,
	output logic [$clog2(MAX_ROW)-1:0]    push_col,
	output logic [6*VALUE_BITS-1:0]       push_data
);
	import ysu_pkg::*;

	localparam int COL_W = $clog2(MAX_ROW);

	logic [COL_W-1:0]      col_q;
	logic [ROW_W-1:0]      row_q;
	logic                  kind_q;

	logic [GRID_SUM_W-1:0] w_raw, w_sat, w_full, w_m1;
	logic [GRID_SUM_W-1:0] h_raw, h_sat, h_full, h_m1;
	logic [CMP_W-1:0]      w16, h16, g16, i16, j16;
	logic                  start, kind_cur;
	logic [COL_W-1:0]      col_cur, col_nxt;
	logic [ROW_W-1:0]      row_cur, row_nxt;
	logic                  in_region, last;

	// Grid size: guards added, clamped to the line buffer and row limit.
	always_comb begin
		w_raw  = GRID_SUM_W'(cfg.interior_width) + GRID_SUM_W'({cfg.guard_cells, 1'b0});
		w_sat  = (w_raw > GRID_SUM_W'(MAX_ROW)) ? GRID_SUM_W'(MAX_ROW) : w_raw;
		w_full = (w_sat == '0) ? GRID_SUM_W'(1) : w_sat;
		w_m1   = w_full - GRID_SUM_W'(1);
		h_raw  = GRID_SUM_W'(cfg.interior_height) + GRID_SUM_W'({cfg.guard_cells, 1'b0});
		h_sat  = (h_raw > GRID_SUM_W'(ROW_LIMIT)) ? GRID_SUM_W'(ROW_LIMIT) : h_raw;
		h_full = (h_sat == '0) ? GRID_SUM_W'(1) : h_sat;
		h_m1   = h_full - GRID_SUM_W'(1);
	end

	// Position of this cell; a sweep start reloads it from the command.
	always_comb begin
		start    = in_user[1];
		kind_cur = start ? in_user[0] : kind_q;
		if (start) begin
			col_cur = (in_user[0] == SWEEP_ELECTRIC) ? '0 : w_m1[COL_W-1:0];
			row_cur = (in_user[0] == SWEEP_ELECTRIC) ? '0 : h_m1[ROW_W-1:0];
		end else begin
			col_cur = col_q;
			row_cur = row_q;
		end
		w16 = CMP_W'(w_full);
		h16 = CMP_W'(h_full);
		g16 = CMP_W'(cfg.guard_cells);
		i16 = CMP_W'(col_cur);
		j16 = CMP_W'(row_cur);
	end

	// Stencil region, last cell and next position for either sweep.
	always_comb begin
		if (kind_cur == SWEEP_MAGNETIC) begin
			in_region = (i16 >= g16) && (i16 + g16 + CMP_W'(2) <= w16) &&
				(j16 >= g16) && (j16 + g16 + CMP_W'(2) <= h16);
			last = (col_cur == '0) && (row_cur == '0);
			if (col_cur == '0) begin
				col_nxt = w_m1[COL_W-1:0];
				row_nxt = (row_cur == '0) ? h_m1[ROW_W-1:0] : row_cur - ROW_W'(1);
			end else begin
				col_nxt = col_cur - COL_W'(1);
				row_nxt = row_cur;
			end
		end else begin
			in_region = (i16 >= g16 + CMP_W'(1)) && (i16 + g16 + CMP_W'(1) <= w16) &&
				(j16 >= g16 + CMP_W'(1)) && (j16 + g16 + CMP_W'(1) <= h16);
			last = (i16 == w16 - CMP_W'(1)) && (j16 == h16 - CMP_W'(1));
			if (i16 + CMP_W'(1) >= w16) begin
				col_nxt = '0;
				row_nxt = (j16 + CMP_W'(1) >= h16) ? '0 : row_cur + ROW_W'(1);
			end else begin
				col_nxt = col_cur + COL_W'(1);
				row_nxt = row_cur;
			end
		end
	end

	// Hand the classified cell to the queue.
	assign push               = in_valid && in_ready;
	assign push_ctl.kind      = kind_cur;
	assign push_ctl.in_region = in_region;
	assign push_ctl.last      = last;
	assign push_col           = col_cur;
	assign push_data          = in_data;

	// Position counters advance on every transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			kind_q <= SWEEP_MAGNETIC;
		end else if (push) begin
			col_q  <= col_nxt;
			row_q  <= row_nxt;
			kind_q <= kind_cur;
		end
	end

endmodule

/* design/ysu_queue.sv */
module ysu_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = ysu_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign in_ready  = (count_q != CNT_W'(DEPTH));
	assign out_valid = (count_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = entry_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= in_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* design/ysu_back.sv */
module ysu_back #(
	parameter int MAX_ROW    = ysu_pkg::MAX_ROW_DEFAULT,
	parameter int VALUE_BITS = ysu_pkg::VALUE_BITS_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ysu_pkg::cfg_t                         cfg,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  ysu_pkg::ctl_t                         in_ctl,
	input  logic [$clog2(MAX_ROW)-1:0]            in_col,
	input  logic [6*VALUE_BITS-1:0]               in_data,  // e_x, e_y, e_z, b_x, b_y, b_z
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((3*VALUE_BITS+7)/8)*8-1:0]     m_tdata,  // out_x, out_y, out_z
	output logic [1:0]                            m_tuser,  // was_updated, saturated
	output logic                                  m_tlast   // sweep_end
);
	import ysu_pkg::*;

	localparam int VB     = VALUE_BITS;
	localparam int COL_W  = $clog2(MAX_ROW);
	localparam int DIFF_W = VB + 1;
	localparam int PROD_W = VB + 18;
	localparam int SCL_W  = VB + 2;
	localparam int SUM_W  = VB + 3;
	localparam int OUT_W  = ((3*VB+7)/8)*8;

	localparam logic signed [SUM_W-1:0] SAT_MAX = {4'b0000, {(VB-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_MIN = {4'b1111, {(VB-1){1'b0}}};

	logic                 adv, pop;

	// Line buffer and neighbor registers.
	logic [2*VB-1:0]      line_mem [MAX_ROW];
	logic [2*VB-1:0]      prior_q;

	// Stage registers.
	logic                 valid_s1, valid_s2, valid_s3;
	ctl_t                 ctl_s1, ctl_s2, ctl_s3;
	logic signed [VB-1:0] base_s1 [3];
	logic signed [VB-1:0] base_s2 [3];
	logic signed [VB-1:0] base_s3 [3];
	logic signed [VB-1:0] own_s1 [4];
	logic [2*VB-1:0]      up_s1, nb_s1;
	logic signed [DIFF_W-1:0] diff_s2 [4];
	logic signed [SCL_W-1:0]  scl_s3 [4];

	// Output register.
	logic                 out_valid_q;
	logic [VB-1:0]        out_q [3];
	logic                 updated_q, clip_q, last_q;

	// Combinational values.
	logic signed [VB-1:0]     ex, ey, ez, bx, by, bz;
	logic signed [VB-1:0]     own_c [4];
	logic signed [VB-1:0]     base_c [3];
	logic signed [VB-1:0]     nbr_c [4];
	logic signed [DIFF_W-1:0] diff_c [4];
	logic signed [PROD_W-1:0] prod_c [4];
	logic signed [SUM_W-1:0]  bext [3];
	logic signed [SUM_W-1:0]  sext [4];
	logic signed [SUM_W-1:0]  sum_c [3];
	logic [VB-1:0]            res_c [3];
	logic [2:0]               clip_c;

	// The whole back advances together whenever the output register frees up.
	assign adv      = !out_valid_q || m_tready;
	assign in_ready = adv;
	assign pop      = in_valid && adv;

	// Split the cell and pick the swept field and the difference operands.
	always_comb begin
		ex = in_data[0*VB +: VB];
		ey = in_data[1*VB +: VB];
		ez = in_data[2*VB +: VB];
		bx = in_data[3*VB +: VB];
		by = in_data[4*VB +: VB];
		bz = in_data[5*VB +: VB];
		if (in_ctl.kind == SWEEP_ELECTRIC) begin
			base_c[0] = ex;
			base_c[1] = ey;
			base_c[2] = ez;
			own_c[0]  = bz;
			own_c[1]  = bz;
			own_c[2]  = by;
			own_c[3]  = bx;
		end else begin
			base_c[0] = bx;
			base_c[1] = by;
			base_c[2] = bz;
			own_c[0]  = ez;
			own_c[1]  = ez;
			own_c[2]  = ey;
			own_c[3]  = ex;
		end
	end

	// Stage 1: line buffer read and write at the column, payload capture.
	always_ff @(posedge clk) begin
		if (pop) begin
			up_s1            <= line_mem[in_col];
			line_mem[in_col] <= {own_c[3], own_c[0]};
			nb_s1            <= prior_q;
			base_s1          <= base_c;
			own_s1           <= own_c;
		end
	end

	// Neighbor operands: row above or below, and the cell before.
	always_comb begin
		nbr_c[0] = up_s1[VB-1:0];
		nbr_c[1] = nb_s1[VB-1:0];
		nbr_c[2] = nb_s1[2*VB-1:VB];
		nbr_c[3] = up_s1[2*VB-1:VB];
		for (int n = 0; n < 4; n++) begin
			if (ctl_s1.kind == SWEEP_ELECTRIC) begin
				diff_c[n] = {own_s1[n][VB-1], own_s1[n]} - {nbr_c[n][VB-1], nbr_c[n]};
			end else begin
				diff_c[n] = {nbr_c[n][VB-1], nbr_c[n]} - {own_s1[n][VB-1], own_s1[n]};
			end
		end
	end

	// Scale each difference; the arithmetic shift rounds toward minus infinity.
	always_comb begin
		prod_c[0] = diff_s2[0] * $signed({1'b0, cfg.ratio_y});
		prod_c[1] = diff_s2[1] * $signed({1'b0, cfg.ratio_x});
		prod_c[2] = diff_s2[2] * $signed({1'b0, cfg.ratio_x});
		prod_c[3] = diff_s2[3] * $signed({1'b0, cfg.ratio_y});
	end

	// Sums of the scaled terms, then saturation to the value range.
	always_comb begin
		for (int n = 0; n < 3; n++) begin
			bext[n] = {{3{base_s3[n][VB-1]}}, base_s3[n]};
		end
		for (int n = 0; n < 4; n++) begin
			sext[n] = {scl_s3[n][SCL_W-1], scl_s3[n]};
		end
		if (ctl_s3.kind == SWEEP_ELECTRIC) begin
			sum_c[0] = bext[0] + sext[0];
			sum_c[1] = bext[1] - sext[1];
			sum_c[2] = bext[2] + sext[2] - sext[3];
		end else begin
			sum_c[0] = bext[0] - sext[0];
			sum_c[1] = bext[1] + sext[1];
			sum_c[2] = bext[2] - sext[2] + sext[3];
		end
		for (int n = 0; n < 3; n++) begin
			if (sum_c[n] > SAT_MAX) begin
				res_c[n]  = SAT_MAX[VB-1:0];
				clip_c[n] = 1'b1;
			end else if (sum_c[n] < SAT_MIN) begin
				res_c[n]  = SAT_MIN[VB-1:0];
				clip_c[n] = 1'b1;
			end else begin
				res_c[n]  = sum_c[n][VB-1:0];
				clip_c[n] = 1'b0;
			end
		end
	end

	// Stages 2 and 3 and the output register payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2  <= ctl_s1;
			base_s2 <= base_s1;
			diff_s2 <= diff_c;
			ctl_s3  <= ctl_s2;
			base_s3 <= base_s2;
			for (int n = 0; n < 4; n++) begin
				scl_s3[n] <= prod_c[n][PROD_W-1:RATIO_BITS];
			end
			for (int n = 0; n < 3; n++) begin
				out_q[n] <= ctl_s3.in_region ? res_c[n] : base_s3[n];
			end
			updated_q <= ctl_s3.in_region;
			clip_q    <= ctl_s3.in_region && (clip_c != 3'b000);
			last_q    <= ctl_s3.last;
		end
	end

	// Control: stage valid bits, the stage 1 class and the cell before.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
			ctl_s1      <= '0;
			prior_q     <= '0;
		end else if (adv) begin
			valid_s1    <= pop;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
			if (pop) begin
				ctl_s1  <= in_ctl;
				prior_q <= {own_c[2], own_c[1]};
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({out_q[2], out_q[1], out_q[0]});
	assign m_tuser  = {clip_q, updated_q};
	assign m_tlast  = last_q;

endmodule
